// ----- hw/rtl/cmi_pkg.sv -----
package cmi_pkg;

	localparam int MAX_NODES_DEF = 16;

	localparam int POS_W   = 16;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 3 * CHAN_W;
	localparam int ENTRY_W = POS_W + COLOR_W;

	localparam int DIFF_W  = POS_W + 1;
	localparam int PROD_W  = 27;
	localparam int REM_W   = 27;
	localparam int QUO_W   = 9;
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W  = $clog2(DIV_STEPS);

	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_INSERT  = 2'd1;
	localparam logic [1:0] ACT_CONVERT = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [1:0]              action;
		logic signed [POS_W-1:0] data_value;
		logic [CHAN_W-1:0]       node_red;
		logic [CHAN_W-1:0]       node_green;
		logic [CHAN_W-1:0]       node_blue;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [1:0]        status;
	} out_item_t;

	function automatic logic [CHAN_W-1:0] chan(input logic [COLOR_W-1:0] color,
		input logic [1:0] idx);
		logic [CHAN_W-1:0] c;
		case (idx)
			CH_RED:   c = color[3*CHAN_W-1:2*CHAN_W];
			CH_GREEN: c = color[2*CHAN_W-1:CHAN_W];
			default:  c = color[CHAN_W-1:0];
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/cmi_stream_if.sv -----
interface cmi_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cmi_ram.sv -----
module cmi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/color_map_interpolator.sv -----
// Piecewise linear color map. The block holds up to MAX_NODES nodes (signed 16-bit
// position plus 8-bit red, green, blue) sorted by position in a table RAM with separate
// read and write ports, and handles one item at a time: req is ready only while the
// block is idle, and a finished result waits in the rsp register while the next item
// may already be taken. Insert walks the table from the top, moving each node above the
// new one up one slot. Convert scans the nodes from the bottom; when the value falls
// between two nodes it interpolates each channel in turn through the shared multiplier
// and the 9-step restoring divider, which rounds to nearest with halves going up. A
// result that is not taken holds the block in its final state. A convert on an empty
// table reports status empty, an insert into a full table reports status full and
// leaves the table as it was.
module color_map_interpolator #(
	parameter int MAX_NODES = cmi_pkg::MAX_NODES_DEF
) (
	input logic clk,
	input logic arst_n,
	cmi_stream_if.sink   req,
	cmi_stream_if.source rsp
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int IW = AW + 1;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_INS_RD  = 10'b0000000010,
		S_INS_CMP = 10'b0000000100,
		S_CV_RD   = 10'b0000001000,
		S_CV_CMP  = 10'b0000010000,
		S_MUL     = 10'b0000100000,
		S_LOAD    = 10'b0001000000,
		S_DIV     = 10'b0010000000,
		S_WB      = 10'b0100000000,
		S_FIN     = 10'b1000000000
	} state_t;

	state_t                             state_q;
	logic [CW-1:0]                      count_q;
	logic [AW-1:0]                      j_q;
	logic [1:0]                         ch_q;
	logic [cmi_pkg::STEP_W-1:0]         k_q;
	logic                               out_valid_q;

	logic signed [cmi_pkg::POS_W-1:0]   x_q;
	logic [cmi_pkg::COLOR_W-1:0]        node_q;
	logic [cmi_pkg::ENTRY_W-1:0]        prev_q;
	logic [cmi_pkg::COLOR_W-1:0]        cur_col_q;
	logic [cmi_pkg::DIFF_W-1:0]         dx_q;
	logic [cmi_pkg::DIFF_W-1:0]         t_q;
	logic signed [cmi_pkg::PROD_W-1:0]  prod_q;
	logic [cmi_pkg::REM_W-1:0]          rem_q;
	logic [cmi_pkg::REM_W-1:0]          dsh_q;
	logic [cmi_pkg::QUO_W-1:0]          quo_q;
	cmi_pkg::out_item_t                 res_q;
	cmi_pkg::out_item_t                 out_q;

	logic                               ram_we;
	logic [AW-1:0]                      ram_raddr;
	logic [cmi_pkg::ENTRY_W-1:0]        ram_wdata;
	logic [cmi_pkg::ENTRY_W-1:0]        ram_rdata;

	logic signed [cmi_pkg::POS_W-1:0]   rd_pos;
	logic [cmi_pkg::COLOR_W-1:0]        rd_col;
	logic signed [cmi_pkg::POS_W-1:0]   prev_pos;
	logic [IW-1:0]                      j_inc;
	logic                               last_node;
	logic                               full;
	logic                               accept;
	logic                               out_load;
	logic signed [cmi_pkg::DIFF_W-1:0]  dx_c;
	logic signed [cmi_pkg::DIFF_W-1:0]  t_c;
	logic [cmi_pkg::CHAN_W-1:0]         c0;
	logic [cmi_pkg::CHAN_W-1:0]         c1;
	logic signed [cmi_pkg::CHAN_W:0]    d_c;
	logic signed [cmi_pkg::DIFF_W:0]    t_s;
	logic signed [cmi_pkg::PROD_W-1:0]  prod_c;
	logic [cmi_pkg::REM_W:0]            num_c;
	logic [cmi_pkg::REM_W:0]            trial;
	logic                               ge;
	logic signed [10:0]                 y_c;
	logic [cmi_pkg::CHAN_W-1:0]         y_sat;

	cmi_ram #(
		.WIDTH(cmi_pkg::ENTRY_W),
		.DEPTH(MAX_NODES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(j_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign accept   = req.valid && req.ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	assign rd_pos    = $signed(ram_rdata[cmi_pkg::ENTRY_W-1:cmi_pkg::COLOR_W]);
	assign rd_col    = ram_rdata[cmi_pkg::COLOR_W-1:0];
	assign prev_pos  = $signed(prev_q[cmi_pkg::ENTRY_W-1:cmi_pkg::COLOR_W]);
	assign j_inc     = IW'(j_q) + IW'(1);
	assign last_node = (j_inc == IW'(count_q));
	assign full      = (count_q == CW'(MAX_NODES));

	assign ram_raddr = (state_q == S_INS_RD) ? (j_q - AW'(1)) : j_q;
	assign ram_we    = ((state_q == S_INS_RD) && (j_q == '0)) || (state_q == S_INS_CMP);
	assign ram_wdata = ((state_q == S_INS_CMP) && (rd_pos > x_q)) ? ram_rdata : {x_q, node_q};

	assign dx_c = {rd_pos[cmi_pkg::POS_W-1], rd_pos} - {prev_pos[cmi_pkg::POS_W-1], prev_pos};
	assign t_c  = {x_q[cmi_pkg::POS_W-1], x_q} - {prev_pos[cmi_pkg::POS_W-1], prev_pos};

	assign c0     = cmi_pkg::chan(prev_q[cmi_pkg::COLOR_W-1:0], ch_q);
	assign c1     = cmi_pkg::chan(cur_col_q, ch_q);
	assign d_c    = $signed({1'b0, c1}) - $signed({1'b0, c0});
	assign t_s    = $signed({1'b0, t_q});
	assign prod_c = d_c * t_s;

	// offset by 512*dx so the dividend stays positive; undone in writeback
	assign num_c = {prod_q, 1'b0} + ({11'b0, dx_q} << 9) + {11'b0, dx_q};

	assign trial = {1'b0, rem_q} - {1'b0, dsh_q};
	assign ge    = !trial[cmi_pkg::REM_W];

	assign y_c = $signed({3'b0, c0}) + $signed({2'b0, quo_q}) - 11'sd256;

	always_comb begin
		if (y_c < 0) begin
			y_sat = '0;
		end else if (y_c > 11'sd255) begin
			y_sat = '1;
		end else begin
			y_sat = y_c[cmi_pkg::CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			j_q         <= '0;
			ch_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.data.action)
							cmi_pkg::ACT_CLEAR: begin
								count_q <= '0;
								state_q <= S_FIN;
							end
							cmi_pkg::ACT_INSERT: begin
								if (full) begin
									state_q <= S_FIN;
								end else begin
									j_q     <= count_q[AW-1:0];
									state_q <= S_INS_RD;
								end
							end
							cmi_pkg::ACT_CONVERT: begin
								j_q     <= '0;
								state_q <= (count_q == '0) ? S_FIN : S_CV_RD;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_INS_RD: begin
					if (j_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_INS_CMP;
					end
				end
				S_INS_CMP: begin
					if (rd_pos > x_q) begin
						j_q     <= j_q - AW'(1);
						state_q <= S_INS_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= S_FIN;
					end
				end
				S_CV_RD: state_q <= S_CV_CMP;
				S_CV_CMP: begin
					if ((j_q == '0) && (x_q < rd_pos)) begin
						state_q <= S_FIN;
					end else if ((j_q != '0) && (rd_pos > x_q)) begin
						ch_q    <= cmi_pkg::CH_RED;
						state_q <= S_MUL;
					end else if (last_node) begin
						state_q <= S_FIN;
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_CV_RD;
					end
				end
				S_MUL: state_q <= S_LOAD;
				S_LOAD: begin
					k_q     <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					k_q <= k_q + cmi_pkg::STEP_W'(1);
					if (k_q == cmi_pkg::STEP_W'(cmi_pkg::DIV_STEPS - 1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (ch_q == cmi_pkg::CH_BLUE) begin
						state_q <= S_FIN;
					end else begin
						ch_q    <= ch_q + 2'd1;
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q         <= req.data.data_value;
					node_q      <= {req.data.node_red, req.data.node_green, req.data.node_blue};
					res_q.red   <= '0;
					res_q.green <= '0;
					res_q.blue  <= '0;
					if ((req.data.action == cmi_pkg::ACT_INSERT) && full) begin
						res_q.status <= cmi_pkg::STAT_FULL;
					end else if ((req.data.action == cmi_pkg::ACT_CONVERT) && (count_q == '0)) begin
						res_q.status <= cmi_pkg::STAT_EMPTY;
					end else begin
						res_q.status <= cmi_pkg::STAT_OK;
					end
				end
			end
			S_CV_CMP: begin
				if ((j_q == '0) && (x_q < rd_pos)) begin
					{res_q.red, res_q.green, res_q.blue} <= rd_col;
				end else if ((j_q != '0) && (rd_pos > x_q)) begin
					dx_q      <= dx_c;
					t_q       <= t_c;
					cur_col_q <= rd_col;
				end else begin
					prev_q <= ram_rdata;
					if (last_node) begin
						{res_q.red, res_q.green, res_q.blue} <= rd_col;
					end
				end
			end
			S_MUL: prod_q <= prod_c;
			S_LOAD: begin
				rem_q <= num_c[cmi_pkg::REM_W-1:0];
				dsh_q <= {1'b0, dx_q, 9'b0};
				quo_q <= '0;
			end
			S_DIV: begin
				if (ge) begin
					rem_q <= trial[cmi_pkg::REM_W-1:0];
				end
				quo_q <= {quo_q[cmi_pkg::QUO_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			S_WB: begin
				case (ch_q)
					cmi_pkg::CH_RED:   res_q.red   <= y_sat;
					cmi_pkg::CH_GREEN: res_q.green <= y_sat;
					default:           res_q.blue  <= y_sat;
				endcase
			end
			S_FIN: begin
				if (out_load) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NODES))
		else $error("node count beyond table size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("ready held after an item was taken");

	a_empty_black: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.data.status == cmi_pkg::STAT_EMPTY)
		|-> (rsp.data.red == '0) && (rsp.data.green == '0) && (rsp.data.blue == '0))
		else $error("empty table result carries a color");
`endif

endmodule

// ----- bench/tb_color_map_interpolator.sv -----
module tb_color_map_interpolator;
	timeunit 1ns;
	timeprecision 1ps;

	import cmi_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam logic [1:0] ACT_RESERVED = 2'd3;
	localparam int ITEM_TARGET = 650;
	localparam int LONG_HOLD = 500;
	localparam int TAIL_CYCLES = 150;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		in_item_t  stim;
		bit        fixed;
		out_item_t want;
	} map_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cmi_stream_if #(.T(in_item_t))  req ();
	cmi_stream_if #(.T(out_item_t)) rsp ();

	color_map_interpolator #(.MAX_NODES(NODES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	logic signed [POS_W-1:0] map_pos [NODES];
	logic [COLOR_W-1:0]      map_rgb [NODES];
	int                      map_count = 0;

	out_item_t pending_colors [$];
	int        mismatches = 0;
	int        counted = 0;
	int        cycle_count = 0;
	bit        quiet = 1'b0;
	bit        hold_off_req = 1'b0;

	always #2 clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic logic [CHAN_W-1:0] blend(input longint x0, input longint x1,
		input longint x, input longint c0, input longint c1);
		longint dx, num, den, q, y;
		dx  = x1 - x0;
		num = 2 * (c1 - c0) * (x - x0) + dx;
		den = 2 * dx;
		q   = num / den;
		if ((num % den) != 0 && num < 0) q--;
		y = c0 + q;
		if (y < 0) y = 0;
		if (y > 255) y = 255;
		return y[CHAN_W-1:0];
	endfunction

	function automatic out_item_t map_lookup(input in_item_t stim);
		out_item_t               res;
		logic signed [POS_W-1:0] x;
		logic [COLOR_W-1:0]      color;
		int                      slot, j, k;
		res   = '0;
		color = '0;
		x     = stim.data_value;
		case (stim.action)
			ACT_CLEAR: begin
				map_count = 0;
			end
			ACT_INSERT: begin
				if (map_count >= NODES) begin
					res.status = STAT_FULL;
				end else begin
					slot = map_count;
					for (j = 0; j < map_count && slot == map_count; j++)
						if (map_pos[j] > x) slot = j;
					for (j = map_count; j > slot; j--) begin
						map_pos[j] = map_pos[j-1];
						map_rgb[j] = map_rgb[j-1];
					end
					map_pos[slot] = x;
					map_rgb[slot] = {stim.node_red, stim.node_green, stim.node_blue};
					map_count++;
				end
			end
			ACT_CONVERT: begin
				if (map_count == 0) begin
					res.status = STAT_EMPTY;
				end else if (x < map_pos[0]) begin
					color = map_rgb[0];
				end else begin
					slot = map_count;
					for (j = 1; j < map_count && slot == map_count; j++)
						if (map_pos[j] > x) slot = j;
					if (slot == map_count) begin
						color = map_rgb[map_count-1];
					end else begin
						for (k = 0; k < 3; k++)
							color[COLOR_W-1-CHAN_W*k -: CHAN_W] = blend(
								longint'(map_pos[slot-1]),
								longint'(map_pos[slot]), longint'(x),
								longint'(map_rgb[slot-1][COLOR_W-1-CHAN_W*k -: CHAN_W]),
								longint'(map_rgb[slot][COLOR_W-1-CHAN_W*k -: CHAN_W]));
					end
				end
				{res.red, res.green, res.blue} = color;
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CHAN_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	function automatic in_item_t make_item(input logic [1:0] act, input logic [POS_W-1:0] value);
		in_item_t it;
		it.action     = act;
		it.data_value = value;
		it.node_red   = pick_level();
		it.node_green = pick_level();
		it.node_blue  = pick_level();
		return it;
	endfunction

	function automatic logic [POS_W-1:0] pick_position(input int spread);
		int roll;
		roll = $urandom_range(0, 7);
		case (spread)
			0: return POS_W'($urandom_range(0, 64) - 32);
			1: return POS_W'($urandom_range(0, 4000) - 2000);
			2: return (roll == 0) ? 16'h8000 : (roll == 1) ? 16'h7FFF : POS_W'($urandom);
			default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] probe_value();
		int base, off, v;
		if (map_count == 0 || $urandom_range(0, 3) == 0) return POS_W'($urandom);
		base = int'(map_pos[$urandom_range(0, map_count - 1)]);
		off  = $urandom_range(0, 40);
		v    = base + off - 20;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return POS_W'(v);
	endfunction

	function automatic map_step_t row(input logic [1:0] act, input int val,
		input logic [COLOR_W-1:0] rgb, input bit fixed = 1'b0,
		input logic [COLOR_W-1:0] want_rgb = '0, input logic [1:0] want_status = STAT_OK);
		map_step_t r;
		r.stim.action     = act;
		r.stim.data_value = POS_W'(val);
		{r.stim.node_red, r.stim.node_green, r.stim.node_blue} = rgb;
		r.fixed = fixed;
		{r.want.red, r.want.green, r.want.blue} = want_rgb;
		r.want.status = want_status;
		return r;
	endfunction

	task automatic send_item(input in_item_t stim, input bit fixed = 1'b0,
		input out_item_t want = '0);
		out_item_t predicted;
		int        gap;
		req.valid <= 1'b1;
		req.data  <= stim;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predicted = map_lookup(stim);
		pending_colors.push_back(fixed ? want : predicted);
		if (stim.action != ACT_RESERVED) counted++;
		gap = quiet ? 0 : gap_len();
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_colors.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d status %0d",
					rsp.data.red, rsp.data.green, rsp.data.blue, rsp.data.status);
				mismatches++;
			end else begin
				want = pending_colors.pop_front();
				if (rsp.data.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, rsp.data.red);
					mismatches++;
				end
				if (rsp.data.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, rsp.data.green);
					mismatches++;
				end
				if (rsp.data.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, rsp.data.blue);
					mismatches++;
				end
				if (rsp.data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.data.status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				stall = quiet ? 0 : gap_len();
				if (stall == 0) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					rsp.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("color_map_interpolator: mismatch");
		$finish;
	end

	initial begin
		map_step_t opening [26];
		int        episode, spread, nodes;
		bit        hold_done;
		episode   = 0;
		hold_done = 1'b0;
		req.valid <= 1'b0;
		req.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		opening = '{
			row(ACT_CONVERT, 0, 24'hA5C3E1, 1'b1, 24'h000000, STAT_EMPTY),
			row(ACT_RESERVED, -1, 24'hFFFFFF, 1'b1),
			row(ACT_INSERT, -32768, 24'h000000, 1'b1),
			row(ACT_INSERT, 32767, 24'hFFFFFF, 1'b1),
			row(ACT_CONVERT, -32768, 24'h123456),
			row(ACT_CONVERT, 32767, 24'h000000, 1'b1, 24'hFFFFFF, STAT_OK),
			row(ACT_CONVERT, 0, 24'hFFFFFF),
			row(ACT_INSERT, 0, 24'hFF0080, 1'b1),
			row(ACT_INSERT, 0, 24'h00FF07, 1'b1),
			row(ACT_CONVERT, 0, 24'h000000),
			row(ACT_INSERT, -32768, 24'h010203, 1'b1),
			row(ACT_CONVERT, -32768, 24'h0F0F0F),
			row(ACT_INSERT, -30000, 24'hC0FFEE, 1'b1),
			row(ACT_INSERT, -1000, 24'h00FF00, 1'b1),
			row(ACT_INSERT, -999, 24'hFF00FF, 1'b1),
			row(ACT_INSERT, 5, 24'h7F8081, 1'b1),
			row(ACT_INSERT, 5, 24'h55AA55, 1'b1),
			row(ACT_INSERT, 200, 24'hFEDCBA, 1'b1),
			row(ACT_INSERT, 12345, 24'h0000FF, 1'b1),
			row(ACT_INSERT, 30000, 24'hFF0000, 1'b1),
			row(ACT_INSERT, 32766, 24'h808080, 1'b1),
			row(ACT_INSERT, -32767, 24'hFFFF00, 1'b1),
			row(ACT_INSERT, 100, 24'h3C3C3C, 1'b1),
			row(ACT_INSERT, 7, 24'h123456, 1'b1, 24'h000000, STAT_FULL),
			row(ACT_CLEAR, 0, 24'hFFFFFF, 1'b1),
			row(ACT_CONVERT, 1, 24'hFFFFFF, 1'b1, 24'h000000, STAT_EMPTY)
		};
		foreach (opening[i]) send_item(opening[i].stim, opening[i].fixed, opening[i].want);
		drain();

		while (counted < ITEM_TARGET) begin
			episode++;
			quiet  = ($urandom_range(0, 4) == 0);
			spread = $urandom_range(0, 3);
			if ($urandom_range(0, 7) != 0) send_item(make_item(ACT_CLEAR, POS_W'($urandom)));
			nodes = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
			repeat (nodes) send_item(make_item(ACT_INSERT, pick_position(spread)));
			repeat ($urandom_range(2, 12)) send_item(make_item(ACT_CONVERT, probe_value()));
			if ($urandom_range(0, 5) == 0)
				send_item(make_item(ACT_RESERVED, POS_W'($urandom)));
			if ($urandom_range(0, 3) == 0)
				send_item(make_item(2'($urandom), POS_W'($urandom)));
			if (!hold_done && counted >= 300) begin
				hold_done    = 1'b1;
				hold_off_req = 1'b1;
			end
			if (episode == 15) drain();
		end

		quiet = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("color_map_interpolator: match");
		else
			$display("color_map_interpolator: mismatch");
		$finish;
	end

endmodule
